// File: hw/rtl/pfd_pkg.sv
// Package with shared constants and types of the pixel repack frame delta block.
package pfd_pkg;

    // Default number of positions in one padded frame.
    localparam int MAX_FRAME_PIXELS_DEF = 262144;

    // Widths of the repacked pixel and of its bytes.
    localparam int BYTE_W  = 8;
    localparam int PIXEL_W = 3 * BYTE_W;

    // Widths of the configuration registers and of the write port.
    localparam int FMT_W   = 2;
    localparam int DIST_W  = 16;
    localparam int CFG_W   = DIST_W;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_DISTANCE = 1'b1;

    // Channel order of the source pixel.
    typedef enum logic [FMT_W-1:0] {
        FMT_BGRX = 2'd0,
        FMT_RGBX = 2'd1,
        FMT_XRGB = 2'd2,
        FMT_XBGR = 2'd3
    } pixel_fmt_t;

endpackage

// File: hw/rtl/pfd_frame_store.sv
// Previous-frame memory: one read-first port that reads and writes the same address.
module pfd_frame_store
    import pfd_pkg::*;
#(
    parameter  int DEPTH  = MAX_FRAME_PIXELS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [PIXEL_W-1:0] wdata,
    output logic [PIXEL_W-1:0] rdata
);

    logic [PIXEL_W-1:0] mem [DEPTH];

    // The read returns the word stored before this write; the new word replaces it.
    always_ff @(posedge aclk) begin
        if (en) begin
            rdata     <= mem[addr];
            mem[addr] <= wdata;
        end
    end

endmodule

// File: hw/rtl/pixel_repack_frame_delta.sv
// Top level of the pixel repacker with frame-difference delta coding and keyframes.
//
// One source pixel word enters per clock and one result word leaves per clock when the
// output side keeps up; a pixel passes stage one and the store's registered read, then
// the output register. Each pixel reads the previous frame's bytes at its position and
// writes its own raw bytes there in the same cycle, so no forwarding is needed. The
// frame store has no reset and no clearing pass: the first frame must be a forced
// keyframe. The user must write configuration only while idle; it is not enforced.
module pixel_repack_frame_delta
    import pfd_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Input pixel stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // pixel_word
    input  logic [2:0]           s_tuser,   // is_padding, frame_start, force_keyframe
    input  logic                 s_tlast,   // frame_end
    // Output byte stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIXEL_W-1:0]   m_tdata,   // out_first, out_second, out_third
    output logic                 m_tuser,   // is_keyframe
    output logic                 m_tlast    // last_of_frame
);

    localparam int POS_W = $clog2(MAX_FRAME_PIXELS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME_PIXELS - 1);

    // Configuration registers.
    pixel_fmt_t         fmt_reg;
    logic [DIST_W-1:0]  dist_reg;

    // Frame control state.
    logic [POS_W-1:0]   pos_reg, pos_next, pos_cur;
    logic [DIST_W-1:0]  fsk_reg, fsk_next;
    logic               key_reg, key_next;

    // Pipeline registers.
    logic               v1_reg, v2_reg;
    logic [PIXEL_W-1:0] raw1_reg;
    logic               key1_reg, last1_reg;
    logic [PIXEL_W-1:0] out_reg;
    logic               key2_reg, last2_reg;

    logic               s_accept, move1;
    logic               pad, start, force_key;
    logic [DIST_W:0]    fsk_inc;
    logic               counted;
    logic [BYTE_W-1:0]  b0, b1, b2;
    logic [PIXEL_W-1:0] raw;
    logic [PIXEL_W-1:0] prev;
    logic [PIXEL_W-1:0] delta;

    assign pad       = s_tuser[0];
    assign start     = s_tuser[1];
    assign force_key = s_tuser[2];

    // Handshake: stage one moves on when the output register is free or being emptied.
    assign move1    = v1_reg && (!v2_reg || m_tready);
    assign s_tready = !v1_reg || move1;
    assign s_accept = s_tvalid && s_tready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg  <= FMT_BGRX;
            dist_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT: fmt_reg  <= pixel_fmt_t'(cfg_wdata[FMT_W-1:0]);
                REG_KEY_DISTANCE: dist_reg <= cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Keyframe decision at the first position of a frame.
    always_comb begin
        fsk_inc  = {1'b0, fsk_reg} + 1'b1;
        counted  = fsk_inc >= {1'b0, dist_reg};
        fsk_next = fsk_reg;
        key_next = key_reg;
        if (start) begin
            fsk_next = counted ? '0 : fsk_inc[DIST_W-1:0];
            key_next = counted || force_key;
        end
    end

    // Position within the frame, wrapping at the store depth and after the last word.
    always_comb begin
        pos_cur  = start ? '0 : pos_reg;
        pos_next = (s_tlast || pos_cur == POS_LAST) ? '0 : pos_cur + 1'b1;
    end

    // Repack the source pixel by channel order; padding gives zero bytes.
    always_comb begin
        b0 = '0;
        b1 = '0;
        b2 = '0;
        if (!pad) begin
            case (fmt_reg)
                FMT_BGRX: begin
                    b0 = s_tdata[7:0];   b1 = s_tdata[15:8];  b2 = s_tdata[23:16];
                end
                FMT_RGBX: begin
                    b0 = s_tdata[23:16]; b1 = s_tdata[15:8];  b2 = s_tdata[7:0];
                end
                FMT_XRGB: begin
                    b0 = s_tdata[31:24]; b1 = s_tdata[23:16]; b2 = s_tdata[15:8];
                end
                default: begin
                    b0 = s_tdata[15:8];  b1 = s_tdata[23:16]; b2 = s_tdata[31:24];
                end
            endcase
        end
        raw = {b2, b1, b0};
    end

    // Control state updates on each accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            fsk_reg <= '0;
            key_reg <= 1'b0;
        end else if (s_accept) begin
            pos_reg <= pos_next;
            fsk_reg <= fsk_next;
            key_reg <= key_next;
        end
    end

    // Previous-frame memory, read and overwritten at the word's position.
    pfd_frame_store #(
        .DEPTH (MAX_FRAME_PIXELS)
    ) u_store (
        .aclk  (aclk),
        .en    (s_accept),
        .addr  (pos_cur),
        .wdata (raw),
        .rdata (prev)
    );

    // Stage one: the word waits beside the memory read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_tready) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            raw1_reg  <= raw;
            key1_reg  <= key_next;
            last1_reg <= s_tlast;
        end
    end

    // Bytewise difference against the previous frame, modulo 256.
    always_comb begin
        delta[7:0]   = raw1_reg[7:0]   - prev[7:0];
        delta[15:8]  = raw1_reg[15:8]  - prev[15:8];
        delta[23:16] = raw1_reg[23:16] - prev[23:16];
    end

    // Stage two: output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (!v2_reg || m_tready) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (move1) begin
            out_reg   <= key1_reg ? raw1_reg : delta;
            key2_reg  <= key1_reg;
            last2_reg <= last1_reg;
        end
    end

    assign m_tvalid = v2_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = key2_reg;
    assign m_tlast  = last2_reg;

`ifndef NO_ASSERTIONS
    // Input stalls only when both pipeline stages hold a word.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg))
        else $error("input stalled with a free pipeline stage");

    // The word after a frame end starts at position zero.
    a_pos_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (pos_reg == '0))
        else $error("position not cleared after frame end");

    // A forced frame start makes the frame a keyframe.
    a_force_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && start && force_key) |=> key_reg)
        else $error("forced keyframe not taken");

    // After a frame start the counter is cleared or below the distance.
    a_fsk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && start && !cfg_wr_en) |=> (fsk_reg == '0 || fsk_reg < dist_reg))
        else $error("frame counter past keyframe distance");
`endif

endmodule

// File: tb/tb_pixel_repack_frame_delta.sv
// Self-checking testbench for the pixel repacker with frame-difference delta coding.
`timescale 1ns / 1ps

module tb_pixel_repack_frame_delta;
    import pfd_pkg::*;

    localparam int FRAME_POS  = MAX_FRAME_PIXELS_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 130;
    localparam int NUM_PHASES  = 8;

    // One source pixel word as it travels on the input stream.
    typedef struct {
        logic [31:0] word;
        logic        pad;
        logic        start;
        logic        last;
        logic        force_key;
    } pix_item_t;

    // One repacked result word.
    typedef struct {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
        logic       key;
        logic       last;
    } packed_px_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;   // pixel_word
    logic [2:0]           s_tuser = '0;   // is_padding, frame_start, force_keyframe
    logic                 s_tlast = 1'b0; // frame_end
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [PIXEL_W-1:0]   m_tdata;   // out_first, out_second, out_third
    logic                 m_tuser;   // is_keyframe
    logic                 m_tlast;   // last_of_frame

    pixel_repack_frame_delta dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Stimulus and expectation stores.
    pix_item_t  pixel_queue[$];
    packed_px_t expected_px[$];
    int         errors = 0;
    int         taken_count = 0;
    int         drv_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    // Channel order and keyframe distance for each random phase.
    logic [1:0]  fmt_plan  [NUM_PHASES] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0};
    logic [15:0] dist_plan [NUM_PHASES] = '{16'd0, 16'd1, 16'd2, 16'd3,
                                           16'hFFFF, 16'd5, 16'd2, 16'd4};

    // Shadow of the block: configuration, keyframe state and the previous frame.
    pixel_fmt_t  fmt_shadow = FMT_BGRX;
    logic [15:0] dist_shadow = '0;
    logic [15:0] since_key = '0;
    logic        cur_key = 1'b0;
    int          frame_pos = 0;
    logic [23:0] prior_px [0:FRAME_POS-1];

    // Generator view of the position, so that no delta frame reads an unwritten entry.
    int gen_pos = 0;
    int gen_extent = 0;
    bit gen_forced = 0;
    int phase_items = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Predict the result word for one accepted pixel and update the shadow state.
    function automatic packed_px_t encode_pixel(pix_item_t it);
        packed_px_t  res;
        logic [7:0]  b0, b1, b2;
        logic [23:0] prev;
        int          nxt;
        bit          counted;
        if (it.start) begin
            nxt = int'(since_key) + 1;
            counted = nxt >= int'(dist_shadow);
            since_key = counted ? 16'd0 : nxt[15:0];
            cur_key = counted || it.force_key;
            frame_pos = 0;
        end
        b0 = '0;
        b1 = '0;
        b2 = '0;
        if (!it.pad) begin
            case (fmt_shadow)
                FMT_BGRX: begin
                    b0 = it.word[7:0];   b1 = it.word[15:8];  b2 = it.word[23:16];
                end
                FMT_RGBX: begin
                    b0 = it.word[23:16]; b1 = it.word[15:8];  b2 = it.word[7:0];
                end
                FMT_XRGB: begin
                    b0 = it.word[31:24]; b1 = it.word[23:16]; b2 = it.word[15:8];
                end
                default: begin
                    b0 = it.word[15:8];  b1 = it.word[23:16]; b2 = it.word[31:24];
                end
            endcase
        end
        prev = prior_px[frame_pos];
        prior_px[frame_pos] = {b2, b1, b0};
        if (cur_key) begin
            res.first  = b0;
            res.second = b1;
            res.third  = b2;
        end else begin
            res.first  = b0 - prev[7:0];
            res.second = b1 - prev[15:8];
            res.third  = b2 - prev[23:16];
        end
        res.key  = cur_key;
        res.last = it.last;
        frame_pos = (it.last || frame_pos == FRAME_POS - 1) ? 0 : frame_pos + 1;
        return res;
    endfunction

    // Queue one pixel and track which frame positions have been written.
    task automatic push_pixel(logic [31:0] word, bit pad, bit start, bit last, bit fk);
        pix_item_t it;
        it.word = word;
        it.pad = pad;
        it.start = start;
        it.last = last;
        it.force_key = fk;
        pixel_queue.insert(pixel_queue.size(), it);
        if (start) begin
            gen_pos = 0;
            gen_forced = fk;
        end
        if (gen_pos >= gen_extent) gen_extent = gen_pos + 1;
        gen_pos = (last || gen_pos == FRAME_POS - 1) ? 0 : gen_pos + 1;
        phase_items++;
    endtask

    // Queue a frame with random content; it is forced to a keyframe on request or when it
    // reaches positions that no earlier frame has written.
    task automatic add_frame(int len, bit force_req, bit with_end);
        bit fk;
        fk = force_req || (len > gen_extent);
        for (int i = 0; i < len; i++) begin
            push_pixel($urandom, $urandom_range(3) == 0, i == 0,
                       with_end && (i == len - 1), (i == 0) ? fk : 1'($urandom_range(1)));
        end
    endtask

    // Queue words outside any frame start, continuing at the running position.
    task automatic add_stray(int n);
        for (int i = 0; i < n && (gen_forced || gen_pos < gen_extent); i++) begin
            push_pixel($urandom, $urandom_range(3) == 0, 1'b0,
                       $urandom_range(3) == 0, 1'($urandom_range(1)));
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_PIXEL_FORMAT) fmt_shadow = pixel_fmt_t'(val[FMT_W-1:0]);
        else dist_shadow = val[DIST_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold the sender until every queued word has gone and every result has come.
    task automatic wait_drained();
        do @(posedge aclk);
        while (pixel_queue.size() != 0 || s_tvalid || expected_px.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    // Driver: present the next word and the receiver's ready at the falling edge.
    always @(negedge aclk) begin
        pix_item_t it;
        bit        go;
        if (taken_count != drv_count || !s_tvalid) begin
            go = pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct;
            if (go) begin
                it = pixel_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.word;
                s_tuser  <= {it.force_key, it.start, it.pad};
                s_tlast  <= it.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        drv_count = taken_count;
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on every accepted pixel, check every accepted result.
    always @(posedge aclk) begin
        pix_item_t  it;
        packed_px_t want;
        if (aresetn && s_tvalid && s_tready) begin
            it.word = s_tdata;
            it.pad = s_tuser[0];
            it.start = s_tuser[1];
            it.force_key = s_tuser[2];
            it.last = s_tlast;
            expected_px.insert(expected_px.size(), encode_pixel(it));
            taken_count++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_px.size() == 0) begin
                $error("result word with no expectation: tdata %h", m_tdata);
                errors++;
            end else begin
                want = expected_px.pop_front();
                if (m_tdata[7:0] !== want.first) begin
                    $error("out_first: expected %h, actual %h", want.first, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] !== want.second) begin
                    $error("out_second: expected %h, actual %h", want.second, m_tdata[15:8]);
                    errors++;
                end
                if (m_tdata[23:16] !== want.third) begin
                    $error("out_third: expected %h, actual %h", want.third, m_tdata[23:16]);
                    errors++;
                end
                if (m_tuser !== want.key) begin
                    $error("is_keyframe: expected %b, actual %b", want.key, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_frame: expected %b, actual %b", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge aclk) begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("pixel_repack_frame_delta: mismatch");
            $finish;
        end
    end

    // Main sequence: reset, directed frames, random phases.
    initial begin
        int r;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // A long distance keeps unforced frames as delta frames.
        cfg_write(REG_PIXEL_FORMAT, CFG_W'(FMT_BGRX));
        cfg_write(REG_KEY_DISTANCE, 16'hFFFF);

        // Forced first keyframe with extreme pixels and padding.
        push_pixel(32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b1);
        push_pixel(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0);
        push_pixel(32'h1234_5678, 1'b0, 1'b0, 1'b0, 1'b1);
        push_pixel(32'h8000_0001, 1'b0, 1'b0, 1'b0, 1'b0);
        push_pixel(32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 1'b0);
        push_pixel(32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0);
        push_pixel(32'hFEDC_BA98, 1'b0, 1'b0, 1'b0, 1'b0);
        push_pixel(32'h00FF_00FF, 1'b0, 1'b0, 1'b1, 1'b0);
        // Delta frame over the same positions, wrapping byte differences both ways.
        push_pixel(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0);
        push_pixel(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1);
        push_pixel(32'h1234_5679, 1'b0, 1'b0, 1'b0, 1'b0);
        push_pixel(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0);
        push_pixel(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0);
        push_pixel(32'h5555_5555, 1'b1, 1'b0, 1'b0, 1'b1);
        push_pixel(32'h0123_4567, 1'b0, 1'b0, 1'b0, 1'b0);
        push_pixel(32'hFF00_FF00, 1'b0, 1'b0, 1'b1, 1'b0);
        // Words after the frame end but before the next start.
        push_pixel(32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0, 1'b1);
        push_pixel(32'hCAFE_F00D, 1'b1, 1'b0, 1'b1, 1'b0);
        // A frame that never ends, cut short by a forced start.
        push_pixel(32'h0F0F_0F0F, 1'b0, 1'b1, 1'b0, 1'b0);
        push_pixel(32'hF0F0_F0F0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_pixel(32'h3C3C_3C3C, 1'b0, 1'b0, 1'b0, 1'b0);
        push_pixel(32'hC3C3_C3C3, 1'b0, 1'b1, 1'b0, 1'b1);
        push_pixel(32'h1111_1111, 1'b0, 1'b0, 1'b0, 1'b0);
        push_pixel(32'h2222_2222, 1'b0, 1'b0, 1'b1, 1'b0);
        // Single-word frame: start and end together.
        push_pixel(32'h9999_9999, 1'b0, 1'b1, 1'b1, 1'b0);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            cfg_write(REG_PIXEL_FORMAT, CFG_W'(fmt_plan[ph]));
            cfg_write(REG_KEY_DISTANCE, dist_plan[ph]);
            phase_items = 0;
            // Mostly well-formed frames, with unterminated frames and strays mixed in.
            while (phase_items < PHASE_ITEMS) begin
                r = $urandom_range(9);
                if (r == 0) add_stray($urandom_range(1, 4));
                else if (r == 1) add_frame($urandom_range(1, 12), $urandom_range(5) == 0, 1'b0);
                else add_frame($urandom_range(1, 20), $urandom_range(5) == 0, 1'b1);
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("pixel_repack_frame_delta: match");
        end else begin
            $display("pixel_repack_frame_delta: mismatch");
        end
        $finish;
    end

endmodule
